@@ rtl/frac_pkg.sv @@
// ----------------------------------------------------------------------------
// Fraction arithmetic package
// Shared constants for the fraction arithmetic unit: default operand width,
// result field widths, operation codes and configuration register map.
// ----------------------------------------------------------------------------
package frac_pkg;

  // Default operand width; the top level hands this down as a parameter.
  localparam int OPERAND_WIDTH_DEF = 16;

  // Fixed widths of the result fields.
  localparam int RES_NUM_W = 33;
  localparam int RES_DEN_W = 32;

  // Operation codes carried by the request type field.
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Configuration port: one 32-bit register, word aligned.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IDX_REDUCE = 1'b0;

endpackage

@@ rtl/fraction_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// Fraction arithmetic unit
// Adds, subtracts, multiplies or divides two signed fractions and optionally
// reduces the result by the greatest common divisor of its two parts.
// ----------------------------------------------------------------------------
// Usage:
// A request carries an operation code and two fractions a and b. It is taken
// when in_valid and in_ready are both high. in_ready is high only while the
// unit is idle, so one request is in work at a time. Each request produces
// exactly one result on the out_ channel, held in an output register until
// out_valid and out_ready are both high.
// Sequence: with reduction off, the request runs through the three products
// on the shared multiplier (S_M0, S_M1, S_M2), the sum (S_ADD) and the
// reduction decision (S_RED), and S_DONE then loads the output register.
// With reduction on, S_RED starts a binary GCD on one subtractor, followed,
// when the divisor is two or more, by two bit-serial divisions; the unit
// waits in S_WAIT until they finish. in_ready returns at the edge that loads
// the result, so a new request is taken only once the last result is in the
// output register. A stalled receiver only holds the finished result;
// the next request is accepted while it waits, and its result is held back
// until the output register frees up. Reset (rst_n low, synchronous)
// returns the sequencers to idle, empties the output register and clears
// reduce_result to 0. The user must write the reduce_result register over
// the APB-style port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module fraction_arithmetic_unit #(
  parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_req_type,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_a_den,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_num,
  input  logic signed [OPERAND_WIDTH-1:0]      in_b_den,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [frac_pkg::RES_NUM_W-1:0] out_res_num,
  output logic signed [frac_pkg::RES_DEN_W-1:0] out_res_den,
  // Configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [frac_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [frac_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [frac_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int W     = OPERAND_WIDTH;
  localparam int PW    = 2 * W;
  // Exact sums of two products need one bit more than a product.
  localparam int NW    = 2 * W + 1;
  localparam int EXT_W = (NW > frac_pkg::RES_NUM_W) ? NW : frac_pkg::RES_NUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_RED  = 3'd5;
  localparam logic [2:0] S_WAIT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [1:0]           op_r;
  logic signed [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic signed [PW-1:0] p0_r, p0_nxt;
  logic signed [PW-1:0] p1_r, p1_nxt;
  logic signed [NW-1:0] num_r, num_nxt;
  logic signed [NW-1:0] den_r, den_nxt;
  logic                 reduce_r;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [frac_pkg::RES_NUM_W-1:0] res_num_r, res_num_nxt;
  logic signed [frac_pkg::RES_DEN_W-1:0] res_den_r, res_den_nxt;

  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic                 red_start;
  logic                 red_done;
  logic signed [NW-1:0] red_num, red_den;
  logic signed [NW-1:0] sel_num, sel_den;
  logic signed [EXT_W-1:0] ext_num, ext_den;
  logic                 in_take;
  logic                 out_load;
  logic                 same_den;
  logic                 cfg_wr;

  // --------------------------------------------------------------------------
  // Configuration register. pready is tied high, so every access completes
  // in its access phase. Only the first word holds a register.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == frac_pkg::REG_IDX_REDUCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reduce_r <= 1'b0;
    end else if (cfg_wr) begin
      reduce_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == frac_pkg::REG_IDX_REDUCE) begin
      prdata[0] = reduce_r;
    end
  end

  // --------------------------------------------------------------------------
  // Request capture and the shared multiplier. The three products are
  // formed one per cycle; each is registered inside the multiplier and
  // picked up one state later.
  // --------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_take) begin
      op_r <= in_req_type;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
  end

  // Product schedule:
  //   add/subtract: a_num*b_den, b_num*a_den, a_den*b_den
  //   multiply:     a_num*b_num, (unused),    a_den*b_den
  //   divide:       a_num*b_den, (unused),    a_den*b_num
  always_comb begin
    unique case (state_r)
      S_M0: begin
        mul_a = an_r;
        mul_b = (op_r == frac_pkg::OP_MUL) ? bn_r : bd_r;
      end
      S_M1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      S_M2: begin
        mul_a = ad_r;
        mul_b = (op_r == frac_pkg::OP_DIV) ? bn_r : bd_r;
      end
      default: begin
        mul_a = an_r;
        mul_b = bd_r;
      end
    endcase
  end

  frac_mul #(
    .W (W)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign p0_nxt = (state_r == S_M1) ? prod : p0_r;
  assign p1_nxt = (state_r == S_M2) ? prod : p1_r;

  always_ff @(posedge clk) begin
    p0_r <= p0_nxt;
    p1_r <= p1_nxt;
  end

  // --------------------------------------------------------------------------
  // Combine step. When both denominators match, add and subtract work on
  // the numerators directly and keep the shared denominator.
  // --------------------------------------------------------------------------
  assign same_den = (ad_r == bd_r);

  always_comb begin
    num_nxt = num_r;
    den_nxt = den_r;
    if (state_r == S_ADD) begin
      den_nxt = NW'(prod);
      unique case (op_r)
        frac_pkg::OP_ADD: begin
          if (same_den) begin
            num_nxt = NW'(an_r) + NW'(bn_r);
            den_nxt = NW'(ad_r);
          end else begin
            num_nxt = NW'(p0_r) + NW'(p1_r);
          end
        end
        frac_pkg::OP_SUB: begin
          if (same_den) begin
            num_nxt = NW'(an_r) - NW'(bn_r);
            den_nxt = NW'(ad_r);
          end else begin
            num_nxt = NW'(p0_r) - NW'(p1_r);
          end
        end
        frac_pkg::OP_MUL, frac_pkg::OP_DIV: begin
          num_nxt = NW'(p0_r);
        end
        default: begin
          num_nxt = NW'(p0_r);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
  end

  // --------------------------------------------------------------------------
  // Reduction. The reducer leaves the fraction unchanged when neither part
  // is positive or when the common divisor is one.
  // --------------------------------------------------------------------------
  assign red_start = (state_r == S_RED) && reduce_r;

  frac_red #(
    .NW (NW)
  ) u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .start (red_start),
    .num   (num_r),
    .den   (den_r),
    .done  (red_done),
    .q_num (red_num),
    .q_den (red_den)
  );

  // --------------------------------------------------------------------------
  // Output register. Exact values are sign extended and then wrapped to the
  // fixed result widths.
  // --------------------------------------------------------------------------
  assign sel_num = reduce_r ? red_num : num_r;
  assign sel_den = reduce_r ? red_den : den_r;
  assign ext_num = EXT_W'(sel_num);
  assign ext_den = EXT_W'(sel_den);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    res_num_nxt   = res_num_r;
    res_den_nxt   = res_den_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      res_num_nxt   = ext_num[frac_pkg::RES_NUM_W-1:0];
      res_den_nxt   = ext_den[frac_pkg::RES_DEN_W-1:0];
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_num_r <= res_num_nxt;
    res_den_r <= res_den_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = res_num_r;
  assign out_res_den = res_den_r;

  // --------------------------------------------------------------------------
  // Request sequencer.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt = S_M0;
        end
      end
      S_M0: state_nxt = S_M1;
      S_M1: state_nxt = S_M2;
      S_M2: state_nxt = S_ADD;
      S_ADD: state_nxt = S_RED;
      S_RED: begin
        state_nxt = reduce_r ? S_WAIT : S_DONE;
      end
      S_WAIT: begin
        if (red_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/frac_mul.sv @@
// ----------------------------------------------------------------------------
// Fraction operand multiplier
// Signed operand-by-operand multiplier with a registered product.
// ----------------------------------------------------------------------------
module frac_mul #(
  parameter int W = frac_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  logic signed [2*W-1:0] p_r;
  logic signed [2*W-1:0] p_nxt;

  // Both operands are signed, so they are sign extended to the full width.
  assign p_nxt = a * b;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

@@ rtl/frac_red.sv @@
// ----------------------------------------------------------------------------
// Fraction reducer
// Binary GCD of the two result magnitudes followed, when that divisor is two
// or more, by two restoring divisions by it, all on one shared subtractor.
// ----------------------------------------------------------------------------
module frac_red #(
  parameter int NW = 2 * frac_pkg::OPERAND_WIDTH_DEF + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic                 done,
  output logic signed [NW-1:0] q_num,
  output logic signed [NW-1:0] q_den
);

  localparam int KW = $clog2(NW);
  localparam int CW = $clog2(NW + 1);
  localparam int SW = NW + 1;

  localparam logic [2:0] R_IDLE = 3'd0;
  localparam logic [2:0] R_GCD  = 3'd1;
  localparam logic [2:0] R_CHK  = 3'd2;
  localparam logic [2:0] R_DIVN = 3'd3;
  localparam logic [2:0] R_LDD  = 3'd4;
  localparam logic [2:0] R_DIVD = 3'd5;
  localparam logic [2:0] R_FIN  = 3'd6;
  localparam logic [2:0] R_DONE = 3'd7;

  function automatic logic [NW-1:0] mag(input logic signed [NW-1:0] v);
    logic [NW-1:0] u;
    u = v;
    mag = v[NW-1] ? (~u + 1'b1) : u;
  endfunction

  logic [2:0]           state_r, state_nxt;
  logic [NW-1:0]        x_r, x_nxt;
  logic [NW-1:0]        y_r, y_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [NW-1:0]        g_r, g_nxt;
  logic [NW-1:0]        rem_r, rem_nxt;
  logic [NW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [NW-1:0] num_r, num_nxt;
  logic signed [NW-1:0] den_r, den_nxt;
  logic signed [NW-1:0] qn_r, qn_nxt;
  logic signed [NW-1:0] qd_r, qd_nxt;

  logic [SW-1:0] sub_a;
  logic [SW-1:0] sub_b;
  logic [SW:0]   diff;
  logic          borrow;
  logic          top_pos;
  logic [NW-1:0] g_sh;
  logic [NW-1:0] quo_neg;

  // One subtractor serves both the GCD steps and the division steps.
  always_comb begin
    if (state_r == R_GCD) begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, y_r};
    end else begin
      sub_a = {rem_r, quo_r[NW-1]};
      sub_b = {1'b0, g_r};
    end
  end

  assign diff    = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow  = diff[SW];
  assign top_pos = (!num[NW-1] && (num != '0)) || (!den[NW-1] && (den != '0));
  assign g_sh    = ((x_r == '0) ? y_r : x_r) << k_r;
  assign quo_neg = ~quo_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    k_nxt     = k_r;
    g_nxt     = g_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          num_nxt = num;
          den_nxt = den;
          x_nxt   = mag(num);
          y_nxt   = mag(den);
          k_nxt   = '0;
          qn_nxt  = num;
          qd_nxt  = den;
          state_nxt = top_pos ? R_GCD : R_DONE;
        end
      end
      R_GCD: begin
        if ((x_r == '0) || (y_r == '0)) begin
          g_nxt     = g_sh;
          state_nxt = R_CHK;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (borrow) begin
          // Keep the larger value in x so the next subtraction stays positive.
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = diff[NW-1:0];
        end
      end
      R_CHK: begin
        if (g_r[NW-1:1] == '0) begin
          state_nxt = R_DONE;
        end else begin
          quo_nxt   = mag(num_r);
          rem_nxt   = '0;
          cnt_nxt   = CW'(NW);
          state_nxt = R_DIVN;
        end
      end
      R_DIVN, R_DIVD: begin
        rem_nxt = borrow ? {rem_r[NW-2:0], quo_r[NW-1]} : diff[NW-1:0];
        quo_nxt = {quo_r[NW-2:0], ~borrow};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = (state_r == R_DIVN) ? R_LDD : R_FIN;
        end
      end
      R_LDD: begin
        qn_nxt    = num_r[NW-1] ? quo_neg : quo_r;
        quo_nxt   = mag(den_r);
        rem_nxt   = '0;
        cnt_nxt   = CW'(NW);
        state_nxt = R_DIVD;
      end
      R_FIN: begin
        qd_nxt    = den_r[NW-1] ? quo_neg : quo_r;
        state_nxt = R_DONE;
      end
      R_DONE: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    k_r   <= k_nxt;
    g_r   <= g_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
  end

  assign done  = (state_r == R_DONE);
  assign q_num = qn_r;
  assign q_den = qd_r;

endmodule
